// File: rtl/core/cor_pkg.sv
// ----------------------------------------------------------------------------
// cor_pkg
// Shared widths, codes and the command word for the circle octant rasterizer.
// ----------------------------------------------------------------------------
package cor_pkg;

	// coordinate and derived widths
	localparam int COORD_BITS = 11;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int SQ_BITS    = 2 * DIFF_BITS;
	localparam int ROOT_BITS  = SQ_BITS / 2;
	localparam int OUT_BITS   = 13;
	localparam int DEC_BITS   = 17;

	// command queue
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_BITS = 1;
	localparam int FIFO_CNT_BITS = 2;

	// item modes
	localparam logic MODE_START   = 1'b0;
	localparam logic MODE_ADVANCE = 1'b1;

	// result status codes
	localparam logic STATUS_POINT = 1'b0;
	localparam logic STATUS_DONE  = 1'b1;

	// decision constants
	localparam logic signed [DEC_BITS-1:0] DEC_BASE  = DEC_BITS'(3);
	localparam logic signed [DEC_BITS-1:0] INC_PLAIN = DEC_BITS'(6);
	localparam logic signed [DEC_BITS-1:0] INC_DIAG  = DEC_BITS'(10);

	// one classified command between front and back
	typedef struct packed {
		logic                         mode;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [SQ_BITS-1:0]           sq;
	} cmd_t;

endpackage

// File: rtl/core/circle_octant_rasterizer_top.sv
// ----------------------------------------------------------------------------
// circle_octant_rasterizer_top
// Midpoint circle generator: start and advance words in, pixel words out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): mode 0 starts a circle from a center
// and an edge point, mode 1 advances one octant step. Output channel
// (out_valid/out_stall): each word is a point or a finished status, with
// last_of_run on the final word caused by one input word.
// A start runs a bit-serial square root in the back end, then emits eight
// points one per cycle while the receiver does not stall. An advance emits
// eight points or one status word, one word per cycle while not stalled.
// The back end sequencer, with its single output register, takes the next
// queued word only once the last word of the current one has been loaded.
// A two-entry command queue lets the front take up to three words ahead.
// Reset (arst_n low) clears the queue, drops any circle and empties the
// output register. When the receiver stalls, the output word holds and the
// back end waits; the front keeps accepting until the queue fills.
// ----------------------------------------------------------------------------
module circle_octant_rasterizer_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic signed [cor_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [cor_pkg::COORD_BITS-1:0] center_y,
	input  logic signed [cor_pkg::COORD_BITS-1:0] edge_x,
	input  logic signed [cor_pkg::COORD_BITS-1:0] edge_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [cor_pkg::OUT_BITS-1:0]   point_x,
	output logic signed [cor_pkg::OUT_BITS-1:0]   point_y,
	output logic                                  status,
	output logic                                  last_of_run
);
	import cor_pkg::*;

	logic push, pop, fifo_full, fifo_empty;
	cmd_t push_cmd, pop_cmd;

	// front end: accept and square
	cor_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.center_x  (center_x),
		.center_y  (center_y),
		.edge_x    (edge_x),
		.edge_y    (edge_y),
		.push      (push),
		.push_cmd  (push_cmd),
		.fifo_full (fifo_full)
	);

	// command queue
	cor_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (fifo_empty)
	);

	// back end: circle state and emitter
	cor_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_cmd     (pop_cmd),
		.empty       (fifo_empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule

// File: rtl/core/cor_front.sv
// ----------------------------------------------------------------------------
// cor_front
// Accepts input words, squares the radius vector and queues a command.
// ----------------------------------------------------------------------------
module cor_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  mode,
	input  logic signed [cor_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [cor_pkg::COORD_BITS-1:0] center_y,
	input  logic signed [cor_pkg::COORD_BITS-1:0] edge_x,
	input  logic signed [cor_pkg::COORD_BITS-1:0] edge_y,
	output logic                                  push,
	output cor_pkg::cmd_t                         push_cmd,
	input  logic                                  fifo_full
);
	import cor_pkg::*;

	logic signed [DIFF_BITS-1:0]   dx, dy;
	logic signed [SQ_BITS-1:0]     sqx_full, sqy_full;
	logic                          valid_s1;
	logic                          mode_s1;
	logic signed [COORD_BITS-1:0]  cx_s1, cy_s1;
	logic [SQ_BITS-1:0]            sqx_s1, sqy_s1;
	logic                          accept;

	// stage holds one word until the queue has room
	assign in_stall = valid_s1 & fifo_full;
	assign accept   = in_valid & ~in_stall;
	assign push     = valid_s1 & ~fifo_full;

	// radius vector and its squares
	assign dx       = DIFF_BITS'(edge_x) - DIFF_BITS'(center_x);
	assign dy       = DIFF_BITS'(edge_y) - DIFF_BITS'(center_y);
	assign sqx_full = dx * dx;
	assign sqy_full = dy * dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			cx_s1   <= center_x;
			cy_s1   <= center_y;
			sqx_s1  <= SQ_BITS'(unsigned'(sqx_full));
			sqy_s1  <= SQ_BITS'(unsigned'(sqy_full));
		end
	end

	// squared distance, summed on the way into the queue
	always_comb begin
		push_cmd.mode = mode_s1;
		push_cmd.cx   = cx_s1;
		push_cmd.cy   = cy_s1;
		push_cmd.sq   = sqx_s1 + sqy_s1;
	end

endmodule

// File: rtl/core/cor_fifo.sv
// ----------------------------------------------------------------------------
// cor_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module cor_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cor_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output cor_pkg::cmd_t pop_cmd,
	output logic          empty
);
	import cor_pkg::*;

	cmd_t                     mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wp_q, rp_q;
	logic [FIFO_CNT_BITS-1:0] cnt_q;

	assign full    = (cnt_q == FIFO_CNT_BITS'(FIFO_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_cmd;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
`endif

endmodule

// File: rtl/core/cor_isqrt.sv
// ----------------------------------------------------------------------------
// cor_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module cor_isqrt (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [cor_pkg::SQ_BITS-1:0]      n,
	output logic                             done,
	output logic [cor_pkg::ROOT_BITS-1:0]    root
);
	import cor_pkg::*;

	logic [SQ_BITS:0] rem_q, res_q, bit_q, trial;
	logic             ge;
	logic             done_q;

	assign trial = res_q + bit_q;
	assign ge    = (rem_q >= trial);
	assign done  = done_q;
	assign root  = res_q[ROOT_BITS-1:0];

	// control: bit_q nonzero while busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (bit_q == (SQ_BITS+1)'(1));
			if (start) begin
				bit_q <= (SQ_BITS+1)'(1) << (SQ_BITS - 2);
			end else begin
				bit_q <= bit_q >> 2;
			end
		end
	end

	// remainder and partial root
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, n};
			res_q <= '0;
		end else if (bit_q != '0) begin
			if (ge) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
		end
	end

endmodule

// File: rtl/core/cor_back.sv
// ----------------------------------------------------------------------------
// cor_back
// Holds the circle state, runs the step or root, and emits result words.
// ----------------------------------------------------------------------------
module cor_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cor_pkg::cmd_t                       pop_cmd,
	input  logic                                empty,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cor_pkg::OUT_BITS-1:0] point_x,
	output logic signed [cor_pkg::OUT_BITS-1:0] point_y,
	output logic                                status,
	output logic                                last_of_run
);
	import cor_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SQRT = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                   state_q;
	logic signed [COORD_BITS-1:0] cx_q, cy_q;
	logic signed [OUT_BITS-1:0]   ox_q, oy_q;
	logic signed [DEC_BITS-1:0]   dec_q;
	logic                         active_q;
	logic                         fin_q;
	logic [2:0]                   k_q;

	logic                         out_valid_q;
	logic signed [OUT_BITS-1:0]   point_x_q, point_y_q;
	logic                         status_q, last_q;

	logic                         sqrt_start, sqrt_done;
	logic [ROOT_BITS-1:0]         sqrt_root;

	logic signed [DEC_BITS-1:0]   dec_nx;
	logic signed [OUT_BITS-1:0]   ox_nx, oy_nx;
	logic                         step_end;
	logic signed [OUT_BITS-1:0]   ax, by, px, py;
	logic                         load, emit;

	cor_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.n      (pop_cmd.sq),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	assign pop        = (state_q == ST_IDLE) & ~empty;
	assign sqrt_start = pop & (pop_cmd.mode == MODE_START);

	// one midpoint step from the current offsets
	always_comb begin
		if (dec_q < 0) begin
			dec_nx = dec_q + (DEC_BITS'(ox_q) <<< 2) + INC_PLAIN;
			oy_nx  = oy_q;
		end else begin
			dec_nx = dec_q + ((DEC_BITS'(ox_q) - DEC_BITS'(oy_q)) <<< 2) + INC_DIAG;
			oy_nx  = oy_q - OUT_BITS'(1);
		end
		ox_nx    = ox_q + OUT_BITS'(1);
		step_end = (oy_nx < ox_nx);
	end

	// mirrored point k: odd k swaps x and y, sign pattern from k[2:1]
	always_comb begin
		ax = k_q[0] ? oy_q : ox_q;
		by = k_q[0] ? ox_q : oy_q;
		px = (k_q[2] ^ k_q[1]) ? OUT_BITS'(cx_q) - ax : OUT_BITS'(cx_q) + ax;
		py = k_q[2] ? OUT_BITS'(cy_q) - by : OUT_BITS'(cy_q) + by;
	end

	// output register takes a new word when empty or drained
	assign load = ~out_valid_q | ~out_stall;
	assign emit = load & (state_q == ST_EMIT);

	// sequencer and circle state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cx_q     <= '0;
			cy_q     <= '0;
			ox_q     <= '0;
			oy_q     <= '0;
			dec_q    <= '0;
			active_q <= 1'b0;
			fin_q    <= 1'b0;
			k_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						k_q <= '0;
						if (pop_cmd.mode == MODE_START) begin
							cx_q    <= pop_cmd.cx;
							cy_q    <= pop_cmd.cy;
							state_q <= ST_SQRT;
						end else begin
							state_q <= ST_EMIT;
							if (!active_q) begin
								fin_q <= 1'b1;
							end else begin
								dec_q    <= dec_nx;
								ox_q     <= ox_nx;
								oy_q     <= oy_nx;
								fin_q    <= step_end;
								active_q <= ~step_end;
							end
						end
					end
				end
				ST_SQRT: begin
					if (sqrt_done) begin
						ox_q     <= '0;
						oy_q     <= OUT_BITS'(sqrt_root);
						dec_q    <= DEC_BASE - (DEC_BITS'(sqrt_root) <<< 1);
						active_q <= 1'b1;
						fin_q    <= 1'b0;
						state_q  <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						k_q <= k_q + 3'd1;
						if (fin_q || k_q == 3'd7) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			point_x_q <= fin_q ? '0 : px;
			point_y_q <= fin_q ? '0 : py;
			status_q  <= fin_q ? STATUS_DONE : STATUS_POINT;
			last_q    <= fin_q | (k_q == 3'd7);
		end
	end

	assign out_valid   = out_valid_q;
	assign point_x     = point_x_q;
	assign point_y     = point_y_q;
	assign status      = status_q;
	assign last_of_run = last_q;

`ifndef SYNTHESIS
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_DONE) |-> last_q)
		else $error("finished word not marked last");
	a_active_in_octant: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> !(oy_q < ox_q))
		else $error("active circle left the octant");
	a_fin_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && fin_q) |-> !active_q)
		else $error("finished word while circle active");
	a_root_in_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> (state_q == ST_SQRT))
		else $error("root ready outside root wait");
`endif

endmodule

// File: tb/circle_octant_rasterizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_octant_rasterizer_checker
// Watches both channels of the rasterizer and predicts each output word.
// ----------------------------------------------------------------------------
// Every accepted input word runs through a midpoint circle model kept here.
// The model holds its own center, offsets and decision value. Each accepted
// output word is checked field by field against the oldest predicted pixel.
// The failure count and the number of pixels still owed go back to the top.
// ----------------------------------------------------------------------------
module circle_octant_rasterizer_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_stall,
	input  logic                                  mode,
	input  logic signed [cor_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [cor_pkg::COORD_BITS-1:0] center_y,
	input  logic signed [cor_pkg::COORD_BITS-1:0] edge_x,
	input  logic signed [cor_pkg::COORD_BITS-1:0] edge_y,
	input  logic                                  out_valid,
	input  logic                                  out_stall,
	input  logic signed [cor_pkg::OUT_BITS-1:0]   point_x,
	input  logic signed [cor_pkg::OUT_BITS-1:0]   point_y,
	input  logic                                  status,
	input  logic                                  last_of_run,
	output int                                    fail_count,
	output int                                    pending_words
);
	import cor_pkg::*;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] px;
		logic signed [OUT_BITS-1:0] py;
		logic                       st;
		logic                       last;
	} pixel_word_t;

	// predicted pixels, oldest first
	pixel_word_t plot_queue[$];

	// circle state
	logic signed [COORD_BITS-1:0] held_cx;
	logic signed [COORD_BITS-1:0] held_cy;
	logic signed [OUT_BITS-1:0]   off_x;
	logic signed [OUT_BITS-1:0]   off_y;
	logic signed [DEC_BITS-1:0]   decision;
	logic                         circle_on;
	int                           errors = 0;

	// floor square root, one bit at a time from the top
	function automatic int unsigned floor_root(input int unsigned n);
		int unsigned root;
		int unsigned trial;
		root = 0;
		for (int b = ROOT_BITS - 1; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (longint'(trial) * longint'(trial) <= longint'(n))
				root = trial;
		end
		return root;
	endfunction

	function automatic void push_pixel(input logic signed [OUT_BITS-1:0] px,
			input logic signed [OUT_BITS-1:0] py, input logic st, input logic last);
		pixel_word_t w;
		w.px = px;
		w.py = py;
		w.st = st;
		w.last = last;
		plot_queue.push_back(w);
	endfunction

	// eight mirrored points of the current offset
	function automatic void queue_octants();
		logic signed [OUT_BITS-1:0] cx;
		logic signed [OUT_BITS-1:0] cy;
		cx = held_cx;
		cy = held_cy;
		push_pixel(cx + off_x, cy + off_y, STATUS_POINT, 1'b0);
		push_pixel(cx + off_y, cy + off_x, STATUS_POINT, 1'b0);
		push_pixel(cx - off_x, cy + off_y, STATUS_POINT, 1'b0);
		push_pixel(cx - off_y, cy + off_x, STATUS_POINT, 1'b0);
		push_pixel(cx - off_x, cy - off_y, STATUS_POINT, 1'b0);
		push_pixel(cx - off_y, cy - off_x, STATUS_POINT, 1'b0);
		push_pixel(cx + off_x, cy - off_y, STATUS_POINT, 1'b0);
		push_pixel(cx + off_y, cy - off_x, STATUS_POINT, 1'b1);
	endfunction

	// one input word: start a circle or take one octant step
	function automatic void rasterize_word(input logic m,
			input logic signed [COORD_BITS-1:0] cxi, input logic signed [COORD_BITS-1:0] cyi,
			input logic signed [COORD_BITS-1:0] exi, input logic signed [COORD_BITS-1:0] eyi);
		int                         dx;
		int                         dy;
		int unsigned                radius;
		logic signed [DEC_BITS-1:0] wx;
		logic signed [DEC_BITS-1:0] wy;
		if (m == MODE_START) begin
			dx = int'(exi) - int'(cxi);
			dy = int'(eyi) - int'(cyi);
			radius = floor_root(dx * dx + dy * dy);
			held_cx = cxi;
			held_cy = cyi;
			off_x = '0;
			off_y = OUT_BITS'(radius);
			decision = DEC_BASE - DEC_BITS'(2 * radius);
			circle_on = 1'b1;
			queue_octants();
		end else if (!circle_on) begin
			push_pixel('0, '0, STATUS_DONE, 1'b1);
		end else begin
			// decision update uses the offsets from before the step
			wx = off_x;
			wy = off_y;
			if (decision < 0) begin
				decision = decision + (wx <<< 2) + INC_PLAIN;
				off_x = off_x + 1;
			end else begin
				decision = decision + ((wx - wy) <<< 2) + INC_DIAG;
				off_x = off_x + 1;
				off_y = off_y - 1;
			end
			if (off_y < off_x) begin
				circle_on = 1'b0;
				push_pixel('0, '0, STATUS_DONE, 1'b1);
			end else begin
				queue_octants();
			end
		end
	endfunction

	// output compare first, so a word never matches a prediction made this edge
	always @(posedge clk or negedge arst_n) begin
		pixel_word_t want;
		if (!arst_n) begin
			plot_queue.delete();
			held_cx = '0;
			held_cy = '0;
			off_x = '0;
			off_y = '0;
			decision = '0;
			circle_on = 1'b0;
			errors = 0;
			fail_count <= 0;
			pending_words <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (plot_queue.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected word x=%0d y=%0d status=%0b last=%0b",
							$realtime, point_x, point_y, status, last_of_run);
				end else begin
					want = plot_queue.pop_front();
					if (point_x !== want.px || point_y !== want.py ||
							status !== want.st || last_of_run !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("%0t: exp %0d,%0d st=%0b l=%0b got %0d,%0d st=%0b l=%0b",
								$realtime, want.px, want.py, want.st, want.last,
								point_x, point_y, status, last_of_run);
					end
				end
			end
			if (in_valid && !in_stall)
				rasterize_word(mode, center_x, center_y, edge_x, edge_y);
			fail_count <= errors;
			pending_words <= plot_queue.size();
		end
	end

endmodule

// File: tb/circle_octant_rasterizer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circle_octant_rasterizer_top_test
// Stimulus and verdict for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
// A directed part covers idle advances, zero and extreme radii, a restart in
// the middle of a circle and a circle stepped to its end. The random part is
// mostly small circles stepped to or past their end, with some large starts,
// stray advances, full drains and quiet stretches. Both channels idle at
// random. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module circle_octant_rasterizer_top_test;
	import cor_pkg::*;

	localparam int RANDOM_WORDS = 232;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int TAIL_CYCLES  = 40;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic                         mode;
	logic signed [COORD_BITS-1:0] center_x;
	logic signed [COORD_BITS-1:0] center_y;
	logic signed [COORD_BITS-1:0] edge_x;
	logic signed [COORD_BITS-1:0] edge_y;
	logic                         out_valid;
	logic                         out_stall;
	logic signed [OUT_BITS-1:0]   point_x;
	logic signed [OUT_BITS-1:0]   point_y;
	logic                         status;
	logic                         last_of_run;
	int                           fail_count;
	int                           pending_words;
	int                           words_sent;
	int                           cycle_count;
	logic                         quiet;

	circle_octant_rasterizer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.center_x    (center_x),
		.center_y    (center_y),
		.edge_x      (edge_x),
		.edge_y      (edge_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.status      (status),
		.last_of_run (last_of_run)
	);

	circle_octant_rasterizer_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.center_x      (center_x),
		.center_y      (center_y),
		.edge_x        (edge_x),
		.edge_y        (edge_y),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.point_x       (point_x),
		.point_y       (point_y),
		.status        (status),
		.last_of_run   (last_of_run),
		.fail_count    (fail_count),
		.pending_words (pending_words)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("circle_octant_rasterizer_top test failed");
		$finish;
	end

	function automatic int rand_coord();
		return int'($urandom_range(0, 2047)) - 1024;
	endfunction

	function automatic int clamp_coord(input int v);
		if (v > 1023)
			return 1023;
		if (v < -1024)
			return -1024;
		return v;
	endfunction

	// sender gaps: mostly none or short, a few long
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (quiet || sel < 55)
			return 0;
		if (sel < 85)
			return $urandom_range(1, 3);
		if (sel < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_word(input logic m, input int cx, input int cy,
			input int ex, input int ey);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		mode <= m;
		center_x <= COORD_BITS'(cx);
		center_y <= COORD_BITS'(cy);
		edge_x <= COORD_BITS'(ex);
		edge_y <= COORD_BITS'(ey);
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
	endtask

	// advance words carry junk in the coordinate fields
	task automatic advance();
		send_word(MODE_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endtask

	// hold off the sender until every predicted pixel is out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_words != 0)
			@(posedge clk);
	endtask

	// receiver stalls: short bursts, occasional long ones, long free runs
	initial begin
		int run;
		int hold;
		int sel;
		forever begin
			if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				sel = $urandom_range(0, 99);
				run = (sel < 70) ? $urandom_range(1, 6) :
					(sel < 90) ? $urandom_range(7, 20) : $urandom_range(30, 80);
				sel = $urandom_range(0, 99);
				hold = (sel < 75) ? $urandom_range(1, 2) :
					(sel < 95) ? $urandom_range(3, 8) : $urandom_range(20, 40);
				out_stall <= 1'b0;
				repeat (run) @(posedge clk);
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
		end
	end

	initial begin
		int stop_at;
		int pick;
		int steps;
		int cx;
		int cy;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_START;
		center_x = '0;
		center_y = '0;
		edge_x = '0;
		edge_y = '0;
		quiet = 1'b0;
		words_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// advance with no circle yet
		advance();
		// zero radius, then its finish, then an advance with nothing active
		send_word(MODE_START, 5, -7, 5, -7);
		advance();
		advance();
		// largest radius, then restarts in the middle of a circle
		send_word(MODE_START, -1024, -1024, 1023, 1023);
		advance();
		advance();
		send_word(MODE_START, 1023, 1023, -1024, -1024);
		advance();
		send_word(MODE_START, 1023, -1024, -1024, 1023);
		// radius one finishes on its first step
		send_word(MODE_START, 0, 0, 1, 0);
		advance();
		// radius three stepped past its end
		send_word(MODE_START, 100, -200, 100, -197);
		repeat (4) advance();
		// squared distance that is not a perfect square
		send_word(MODE_START, 0, 0, 3, 5);
		repeat (3) advance();
		drain_results();

		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at) begin
			pick = $urandom_range(0, 19);
			if (pick < 13) begin
				// small circle, usually run to its end
				cx = rand_coord();
				cy = rand_coord();
				send_word(MODE_START, cx, cy,
					clamp_coord(cx + int'($urandom_range(0, 30)) - 15),
					clamp_coord(cy + int'($urandom_range(0, 30)) - 15));
				steps = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) :
					$urandom_range(8, 16);
				repeat (steps) advance();
			end else if (pick < 15) begin
				// large circle, cut short
				send_word(MODE_START, rand_coord(), rand_coord(), rand_coord(), rand_coord());
				repeat ($urandom_range(0, 3)) advance();
			end else if (pick < 18) begin
				repeat ($urandom_range(1, 3)) advance();
			end else begin
				drain_results();
				quiet = ~quiet;
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("circle_octant_rasterizer_top test passed");
		else
			$display("circle_octant_rasterizer_top test failed");
		$finish;
	end

endmodule
